@@ rtl/core/wnm_pkg.sv @@
// Shared types and constants of the wildcard name matcher.
// Used by the register block, the matching core and the top level; no dependencies.
package wnm_pkg;

  // Default number of pattern positions that the matcher tracks.
  localparam int MAX_PATTERN_CHARS_DEF = 32;

  // Pattern bytes that the register file can hold (four 64-bit words).
  localparam int PATTERN_CHARS = 32;
  localparam int PATTERN_BITS  = PATTERN_CHARS * 8;

  localparam int LEN_REG_W  = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QMARK_CHAR = 8'h3F;

  // Register index, taken from the 8-byte aligned configuration address.
  typedef enum logic [2:0] {
    REG_LENGTH  = 3'd0,
    REG_CHARS_0 = 3'd1,
    REG_CHARS_1 = 3'd2,
    REG_CHARS_2 = 3'd3,
    REG_CHARS_3 = 3'd4
  } reg_idx_t;

  // Current pattern as seen by the matching core.
  typedef struct packed {
    logic [LEN_REG_W-1:0]    length;
    logic [PATTERN_BITS-1:0] chars;
  } wnm_cfg_t;

endpackage

@@ rtl/core/wnm_cfg_regs.sv @@
// Configuration registers of the wildcard name matcher: pattern length and pattern bytes.
// Register access over an APB-style port; depends on wnm_pkg.
module wnm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wnm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wnm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wnm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output wnm_pkg::wnm_cfg_t              cfg
);

  logic [wnm_pkg::LEN_REG_W-1:0]  length_r;
  logic [wnm_pkg::CFG_DATA_W-1:0] chars_r [4];
  wnm_pkg::reg_idx_t              reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = wnm_pkg::reg_idx_t'(paddr[wnm_pkg::CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r   <= '0;
      chars_r[0] <= '0;
      chars_r[1] <= '0;
      chars_r[2] <= '0;
      chars_r[3] <= '0;
    end else if (wr_en) begin
      // Writes to addresses beyond the register list are dropped.
      unique case (reg_idx)
        wnm_pkg::REG_LENGTH:  length_r   <= pwdata[wnm_pkg::LEN_REG_W-1:0];
        wnm_pkg::REG_CHARS_0: chars_r[0] <= pwdata;
        wnm_pkg::REG_CHARS_1: chars_r[1] <= pwdata;
        wnm_pkg::REG_CHARS_2: chars_r[2] <= pwdata;
        wnm_pkg::REG_CHARS_3: chars_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wnm_pkg::REG_LENGTH:  prdata = {{(wnm_pkg::CFG_DATA_W-wnm_pkg::LEN_REG_W){1'b0}}, length_r};
      wnm_pkg::REG_CHARS_0: prdata = chars_r[0];
      wnm_pkg::REG_CHARS_1: prdata = chars_r[1];
      wnm_pkg::REG_CHARS_2: prdata = chars_r[2];
      wnm_pkg::REG_CHARS_3: prdata = chars_r[3];
      default:              prdata = '0;
    endcase
  end

  assign cfg.length = length_r;
  assign cfg.chars  = {chars_r[3], chars_r[2], chars_r[1], chars_r[0]};

endmodule

@@ rtl/core/wnm_nfa.sv @@
// Bit-parallel NFA of the wildcard matcher: holds the set of reached pattern positions
// and advances all of them by one name byte per step. Depends on wnm_pkg.
module wnm_nfa #(
  parameter int MAX_PATTERN_CHARS = wnm_pkg::MAX_PATTERN_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_valid,
  input  logic              step_last,
  input  logic [7:0]        step_char,
  input  wnm_pkg::wnm_cfg_t cfg,
  output logic              matched
);

  localparam int NP     = MAX_PATTERN_CHARS + 1;
  localparam int LEN_W  = $clog2(NP);
  localparam int CMP_W  = wnm_pkg::LEN_REG_W + 1;
  localparam logic [NP-1:0] START_SET = NP'(1);

  logic [NP-1:0]    state_r;
  logic [NP-1:0]    state_nxt;
  logic [NP-1:0]    star_m;
  logic [NP-1:0]    adv_m;
  logic [NP-1:0]    cur_set;
  logic [NP-1:0]    moved_set;
  logic [NP-1:0]    raw_set;
  logic [NP-1:0]    closed_set;
  logic [LEN_W-1:0] used_len;

  // A reached star also reaches the following position, and that chains through a run of
  // stars. The add carries from each reached star to the end of its run of stars.
  function automatic logic [NP-1:0] star_closure(input logic [NP-1:0] a,
                                                 input logic [NP-1:0] s);
    logic [NP:0] sum;
    sum = {1'b0, a & s} + {1'b0, s};
    star_closure = a | (sum[NP-1:0] ^ s);
  endfunction

  always_comb begin
    if ({1'b0, cfg.length} > CMP_W'(MAX_PATTERN_CHARS)) begin
      used_len = LEN_W'(MAX_PATTERN_CHARS);
    end else begin
      used_len = LEN_W'(cfg.length);
    end
  end

  for (genvar i = 0; i < MAX_PATTERN_CHARS; i++) begin : g_pos
    logic [7:0] pch;
    logic       in_use;
    if (i < wnm_pkg::PATTERN_CHARS) begin : g_reg
      assign pch = cfg.chars[8*i +: 8];
    end else begin : g_zero
      assign pch = 8'h00;
    end
    assign in_use   = LEN_W'(i) < used_len;
    assign star_m[i] = in_use && (pch == wnm_pkg::STAR_CHAR);
    assign adv_m[i]  = in_use && (pch != wnm_pkg::STAR_CHAR) &&
                       ((pch == wnm_pkg::QMARK_CHAR) || (pch == step_char));
  end
  assign star_m[MAX_PATTERN_CHARS] = 1'b0;
  assign adv_m[MAX_PATTERN_CHARS]  = 1'b0;

  // The closure is applied again before the step, since the pattern may change mid-name.
  assign cur_set    = star_closure(state_r, star_m);
  assign moved_set  = cur_set & adv_m;
  assign raw_set    = (cur_set & star_m) | {moved_set[NP-2:0], 1'b0};
  assign closed_set = star_closure(raw_set, star_m);
  assign matched    = (used_len == '0) || closed_set[used_len];

  always_comb begin
    state_nxt = state_r;
    if (step_valid) begin
      state_nxt = step_last ? START_SET : closed_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= START_SET;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/wildcard_name_matcher.sv @@
// Wildcard name matcher: one name byte per cycle, except that a name's last byte waits in the
// input register while the result register holds a result not yet taken. out_tvalid rises once
// that last byte has passed the input register and then the result register.
// The cycle is set by the position-set loop in wnm_nfa (two carry chains across the pattern
// width). Reset (rst_n low, synchronous) clears the valid flags of both pipeline registers,
// restarts the position set at position zero and zeroes the configuration registers.
module wildcard_name_matcher #(
  parameter int MAX_PATTERN_CHARS = wnm_pkg::MAX_PATTERN_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] name_char
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [0] matched, [7:1] zero
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wnm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wnm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wnm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  wnm_pkg::wnm_cfg_t cfg_w;

  logic       in_valid_r;
  logic       in_valid_nxt;
  logic [7:0] in_char_r;
  logic       in_last_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_matched_r;
  logic       advance;
  logic       in_accept;
  logic       nfa_matched;

  wnm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg_w)
  );

  wnm_nfa #(
    .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS)
  ) u_nfa (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (advance),
    .step_last  (in_last_r),
    .step_char  (in_char_r),
    .cfg        (cfg_w),
    .matched    (nfa_matched)
  );

  // A byte that is not the last always moves on; the last byte needs room for its result.
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && in_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && in_last_r) begin
      out_matched_r <= nfa_matched;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_matched_r};

  // A result only ever comes from the last byte of a name.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r && in_last_r))
    else $error("result raised without a last byte in the input register");

  // A last byte waits in place while the previous result is not taken.
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && in_last_r && out_valid_r && !out_tready) |=>
    (in_valid_r && in_last_r && $stable(in_char_r)))
    else $error("last byte lost while the result register was full");

  // An empty pattern matches every name.
  a_empty_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r && (cfg_w.length == '0)) |=> (out_valid_r && out_matched_r))
    else $error("empty pattern did not report a match");

endmodule
